>>> hw/rtl/rpf_pkg.sv
// rpf_pkg: shared constants, item codes, word-stage struct and the crc-32 word update
// depends on nothing; used by every module of the packet framer

package rpf_pkg;

  localparam logic [31:0] HEADER_WORD = 32'hCAFE8000;
  localparam logic [31:0] CRC_POLY    = 32'h04C11DB7;

  // item codes on the mode field
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  // one packet word leaving the sequencer, with its crc action
  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        emit;
    logic        clear;
    logic        feed;
  } rpf_word_t;

  // crc-32, msb first, no reflection: one 32-bit word per call
  function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] data);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 31; i >= 0; i--) begin
      fb = c[31] ^ data[i];
      c  = {c[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/rpf_ifs.sv
// rpf_ifs: valid/ready channel interfaces for the packet framer
// input item channel and output word channel; no dependencies

interface rpf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] payload_length;
  logic [31:0] trigger_number;
  logic [63:0] roi_entry;

  modport source (output valid, mode, payload_length, trigger_number, roi_entry, input ready);
  modport sink   (input valid, mode, payload_length, trigger_number, roi_entry, output ready);
endinterface

interface rpf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        last_word;

  modport source (output valid, out_word, last_word, input ready);
  modport sink   (input valid, out_word, last_word, output ready);
endinterface

>>> hw/rtl/rpf_sequencer.sv
// rpf_sequencer: item holding register and word sequencer
// depends on rpf_pkg and rpf_in_if; emits one packet word per cycle while an item is held and can_load is high

module rpf_sequencer (
  input  logic               clk,
  input  logic               rst,
  rpf_in_if.sink             in_ch,
  input  logic               can_load,
  input  logic [31:0]        crc,
  output rpf_pkg::rpf_word_t wsel
);
  import rpf_pkg::*;

  logic        busy;
  logic [1:0]  mode;
  logic [1:0]  idx;
  logic [31:0] len;
  logic [31:0] trig;
  logic [63:0] entry;

  logic has_word;
  logic final_word;
  logic done;
  logic accept;

  always_comb begin
    wsel       = '0;
    has_word   = 1'b1;
    final_word = 1'b0;
    case (mode)
      MODE_START: begin
        case (idx)
          2'd0: begin
            wsel.word  = len;
            wsel.clear = 1'b1;
          end
          2'd1: begin
            wsel.word = HEADER_WORD;
            wsel.feed = 1'b1;
          end
          default: begin
            wsel.word  = trig;
            wsel.feed  = 1'b1;
            final_word = 1'b1;
          end
        endcase
      end
      MODE_ADD: begin
        wsel.feed = 1'b1;
        if (idx == 2'd0) begin
          wsel.word = entry[63:32];
        end else begin
          wsel.word  = entry[31:0];
          final_word = 1'b1;
        end
      end
      MODE_CLOSE: begin
        wsel.word  = crc;
        wsel.last  = 1'b1;
        final_word = 1'b1;
      end
      default: begin
        // unused code: dropped without a word
        has_word   = 1'b0;
        final_word = 1'b1;
      end
    endcase
    wsel.emit = busy && has_word && can_load;
  end

  assign done        = busy && (has_word ? (can_load && final_word) : 1'b1);
  assign in_ch.ready = !busy || done;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (accept) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (wsel.emit) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode  <= in_ch.mode;
      len   <= in_ch.payload_length;
      trig  <= in_ch.trigger_number;
      entry <= in_ch.roi_entry;
    end
  end

endmodule

>>> hw/rtl/rpf_crc.sv
// rpf_crc: running crc-32 register, fed one packet word per cycle while the sequencer emits words
// depends on rpf_pkg for the word struct and the update function

module rpf_crc (
  input  logic               clk,
  input  logic               rst,
  input  rpf_pkg::rpf_word_t wsel,
  output logic [31:0]        crc
);
  import rpf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= 32'h0;
    end else if (wsel.emit && wsel.clear) begin
      crc <= 32'h0;
    end else if (wsel.emit && wsel.feed) begin
      crc <= crc32_word(crc, wsel.word);
    end
  end

endmodule

>>> hw/rtl/roi_packet_framer_crc32_unit.sv
// roi_packet_framer_crc32_unit: top level of the crc-32 packet framer
// depends on rpf_pkg, rpf_ifs, rpf_sequencer and rpf_crc
//
// usage
//   in_ch carries one item per word handshake: start (length, trigger),
//   add (64-bit entry) or close. out_ch carries the packet, one 32-bit
//   word per handshake, last_word high on the crc word.
//   a start gives length, header 0xcafe8000 and trigger; an add gives the
//   entry high word then low word; a close gives the running crc.
//   the crc covers every word after the length word up to the crc word, msb first.
// sequencing
//   an item is taken into the holding register at the accepting edge and its
//   first word enters the output register once that register can load.
//   the output register takes one word per cycle while it can load; a start
//   holds the sequencer for three words, an add two, a close one, and the
//   unused code is dropped without a word. the next item is accepted in the
//   cycle its predecessor's last word moves on.
// reset
//   clears the crc to zero and empties the holding and output registers.
// stalls
//   while out_ch.ready is low a held output word stays, the sequencer waits
//   once the output register is full, and in_ch.ready drops once an item is held.

module roi_packet_framer_crc32_unit (
  input  logic     clk,
  input  logic     rst,
  rpf_in_if.sink   in_ch,
  rpf_out_if.source out_ch
);
  import rpf_pkg::*;

  rpf_word_t   wsel;
  logic [31:0] crc;
  logic        can_load;
  logic        out_valid;

  // output register frees when empty or when its word is taken
  assign can_load = !out_valid || out_ch.ready;

  rpf_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .can_load (can_load),
    .crc      (crc),
    .wsel     (wsel)
  );

  // crc register updates as each covered word enters the output register
  rpf_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .wsel (wsel),
    .crc  (crc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wsel.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wsel.emit) begin
      out_ch.out_word  <= wsel.word;
      out_ch.last_word <= wsel.last;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

>>> tb/sv/rpf_framer_checker.sv
`timescale 1ns / 100ps
// rpf_framer_checker: watches both channels of the packet framer, predicts each packet word
// and compares it with what leaves the block; depends on rpf_pkg and rpf_ifs

module rpf_framer_checker (
  input  logic clk,
  input  logic rst,
  rpf_in_if    in_ch,
  rpf_out_if   out_ch,
  output int   fail_count,
  output int   words_pending
);
  import rpf_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } packet_word_t;

  packet_word_t packet_words_q[$];
  logic [31:0]  crc_acc;

  // msb-first crc-32 over one byte, no reflection
  function automatic logic [31:0] crc32_step_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] crc32_step_word(input logic [31:0] acc, input logic [31:0] w);
    logic [31:0] c;
    c = acc;
    for (int s = 3; s >= 0; s--) begin
      c = crc32_step_byte(c, w[s*8 +: 8]);
    end
    return c;
  endfunction

  function automatic void push_word(input logic [31:0] w, input logic last);
    packet_word_t pw;
    pw.word = w;
    pw.last = last;
    packet_words_q.push_back(pw);
  endfunction

  // expected packet words for one accepted item
  task automatic frame_item(input logic [1:0] mode, input logic [31:0] len,
                            input logic [31:0] trig, input logic [63:0] entry);
    case (mode)
      MODE_START: begin
        crc_acc = crc32_step_word(32'h0, HEADER_WORD);
        crc_acc = crc32_step_word(crc_acc, trig);
        push_word(len, 1'b0);
        push_word(HEADER_WORD, 1'b0);
        push_word(trig, 1'b0);
      end
      MODE_ADD: begin
        crc_acc = crc32_step_word(crc_acc, entry[63:32]);
        crc_acc = crc32_step_word(crc_acc, entry[31:0]);
        push_word(entry[63:32], 1'b0);
        push_word(entry[31:0], 1'b0);
      end
      MODE_CLOSE: begin
        push_word(crc_acc, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    fail_count    = 0;
    words_pending = 0;
    crc_acc       = 32'h0;
  end

  always @(posedge clk) begin
    packet_word_t exp_w;
    if (rst) begin
      crc_acc = 32'h0;
      packet_words_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        frame_item(in_ch.mode, in_ch.payload_length, in_ch.trigger_number, in_ch.roi_entry);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (packet_words_q.size() == 0) begin
          $error("unexpected word: out_word %h last_word %b", out_ch.out_word,
                 out_ch.last_word);
          fail_count++;
        end else begin
          exp_w = packet_words_q.pop_front();
          if (out_ch.out_word !== exp_w.word) begin
            $error("out_word mismatch: expected %h actual %h", exp_w.word, out_ch.out_word);
            fail_count++;
          end
          if (out_ch.last_word !== exp_w.last) begin
            $error("last_word mismatch: expected %b actual %b", exp_w.last, out_ch.last_word);
            fail_count++;
          end
        end
      end
    end
    words_pending = packet_words_q.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for roi_packet_framer_crc32_unit
// depends on rpf_pkg, rpf_ifs, the framer rtl and rpf_framer_checker

module tb;
  import rpf_pkg::*;

  // code the block drops without a word
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // cycles without any handshake before the run is called hung
  localparam int WATCHDOG_LIMIT = 3000;
  // random part stops once this many non-ignored items have gone in
  localparam int ITEM_TARGET = 470;
  // settle time after the last expected word
  localparam int TAIL_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rpf_in_if  in_ch ();
  rpf_out_if out_ch ();

  int fail_count;
  int words_pending;
  int items_sent;
  int idle_cycles;
  // calm stretches: no gaps on the input and no stalls on the output
  bit calm;

  roi_packet_framer_crc32_unit dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  rpf_framer_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short pauses, the odd long one
  function automatic int idle_span();
    if ($urandom_range(0, 19) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // random word with the corners turning up often
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // one item onto in_ch; returns at the edge where it is taken
  task automatic send_item(input logic [1:0] mode, input logic [31:0] len,
                           input logic [31:0] trig, input logic [63:0] entry);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 35) begin
      gap = idle_span();
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= mode;
    in_ch.payload_length <= len;
    in_ch.trigger_number <= trig;
    in_ch.roi_entry      <= entry;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (mode != MODE_UNUSED) begin
      items_sent++;
    end
  endtask

  // unused fields carry junk on purpose, the block must ignore them
  task automatic send_start(input logic [31:0] len, input logic [31:0] trig);
    send_item(MODE_START, len, trig, {rand_word(), rand_word()});
  endtask

  task automatic send_add(input logic [63:0] entry);
    send_item(MODE_ADD, rand_word(), rand_word(), entry);
  endtask

  task automatic send_close();
    send_item(MODE_CLOSE, rand_word(), rand_word(), {rand_word(), rand_word()});
  endtask

  // well-formed packet: start, a few entries, close
  task automatic send_random_packet();
    int n_entries;
    if ($urandom_range(0, 9) == 0) begin
      n_entries = $urandom_range(7, 40);
    end else begin
      n_entries = $urandom_range(0, 6);
    end
    send_start(rand_word(), rand_word());
    repeat (n_entries) send_add({rand_word(), rand_word()});
    send_close();
    // a repeated close gives the same crc word again
    if ($urandom_range(0, 9) == 0) begin
      send_close();
    end
  endtask

  // output side pacing: random stalls outside calm stretches
  initial begin : sink_pacing
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        // ready already low, hold it
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
        out_ch.ready <= 1'b0;
        stall_left = idle_span() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: any handshake on either channel resets the count
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("roi_packet_framer_crc32_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int pick;
    in_ch.valid          = 1'b0;
    in_ch.mode           = MODE_START;
    in_ch.payload_length = 32'h0;
    in_ch.trigger_number = 32'h0;
    in_ch.roi_entry      = 64'h0;
    items_sent           = 0;
    idle_cycles          = 0;
    calm                 = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part
    // close straight after reset: crc still zero
    send_close();
    // entry with no start, crc runs on from zero
    send_add(64'h0123_4567_89AB_CDEF);
    send_close();
    // unused code, nothing should come out
    send_item(MODE_UNUSED, rand_word(), rand_word(), {rand_word(), rand_word()});
    send_start(32'h0000_0000, 32'h0000_0000);
    send_close();
    send_close();
    send_start(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_add(64'hFFFF_FFFF_FFFF_FFFF);
    send_add(64'h0000_0000_0000_0000);
    send_add(64'h8000_0000_0000_0001);
    send_close();
    send_start(32'h1234_5678, HEADER_WORD);
    send_add({HEADER_WORD, 32'h0});
    send_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_add(64'hFFFF_FFFF_0000_0000);
    send_close();
    // restart mid-packet: second start clears the crc
    send_start(rand_word(), rand_word());
    send_add(64'h0000_0000_FFFF_FFFF);
    send_start(rand_word(), rand_word());
    send_close();

    // random part: mostly whole packets, some stray items
    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_random_packet();
      end else begin
        send_item(2'($urandom_range(0, 3)), rand_word(), rand_word(),
                  {rand_word(), rand_word()});
      end
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    // drain, then let any stray word show itself
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("roi_packet_framer_crc32_unit regression: pass");
    end else begin
      $display("roi_packet_framer_crc32_unit regression: fail");
    end
    $finish;
  end

endmodule
